// File: rtl/bspf_pkg.sv
`default_nettype none

package bspf_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int PATTERN_BYTES   = 16;
	localparam int LEN_W           = 5;
	localparam int CFG_W           = 64;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
		logic       file_end;
		logic       new_search;
	} item_t;

	typedef struct packed {
		logic file_found;
		logic file_done;
		logic any_found;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/byte_stream_pattern_finder.sv
`default_nettype none

// channel   direction  handshake                      payload
// item      in         item_valid / item_ready        bspf_pkg::item_t
// result    out        result_valid / result_ready    bspf_pkg::result_t
// config    in         wr_en (no wait)                wr_index, wr_data
//
// one byte per cycle sustained while the result side is not stalled; an item passes the input stage, then the result
// register: an input stage register feeds the window compare, which writes the result register
// the window and match flags update when the input stage moves into the result register
// a stalled result holds the input stage; item_ready drops only when both are full
// reset clears the valid and seen flags, the byte window, the fill count and the pattern bytes, and sets length to one

module byte_stream_pattern_finder #(
	parameter int MAX_PATTERN = bspf_pkg::MAX_PATTERN_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 item_valid,
	output logic                                item_ready,
	input  bspf_pkg::item_t                     item,
	output logic                                result_valid,
	input  wire                                 result_ready,
	output bspf_pkg::result_t                   result,
	input  wire                                 wr_en,
	input  wire  [bspf_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire  [bspf_pkg::CFG_W-1:0]          wr_data
);

	localparam int LW    = bspf_pkg::LEN_W;
	localparam int CW    = $clog2(MAX_PATTERN + 1);
	localparam int DEPTH = MAX_PATTERN - 1;
	localparam int PB    = bspf_pkg::PATTERN_BYTES;

	logic [bspf_pkg::CFG_W-1:0] pat_low_q;
	logic [bspf_pkg::CFG_W-1:0] pat_high_q;
	logic [LW-1:0]              pat_len_q;

	logic              valid_s1;
	bspf_pkg::item_t   item_s1;
	logic              adv_s1;

	logic [7:0]        recent_q [DEPTH];
	logic [CW-1:0]     seen_cnt_q;
	logic              seen_file_q;
	logic              seen_search_q;

	logic [LW-1:0]     len;
	logic [CW-1:0]     cnt_next;
	logic              file_clr;
	logic              search_clr;
	logic              match;
	logic [MAX_PATTERN-1:0] eq;
	logic [7:0]        hist [MAX_PATTERN];
	logic [8*PB-1:0]   pat_all;

	assign pat_all = {pat_high_q, pat_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= LW'(1);
		end else if (wr_en) begin
			case (wr_index)
				bspf_pkg::REG_PATTERN_LOW:  pat_low_q  <= wr_data;
				bspf_pkg::REG_PATTERN_HIGH: pat_high_q <= wr_data;
				bspf_pkg::REG_PATTERN_LEN:  pat_len_q  <= wr_data[LW-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s1     = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// clamp length into 1..MAX_PATTERN
	always_comb begin
		len = pat_len_q;
		if (len == '0) begin
			len = LW'(1);
		end
		if (int'(len) > MAX_PATTERN) begin
			len = LW'(MAX_PATTERN);
		end
	end

	always_comb begin
		file_clr   = item_s1.file_start;
		search_clr = item_s1.new_search;
		cnt_next   = file_clr ? '0 : seen_cnt_q;
		if (int'(cnt_next) < MAX_PATTERN) begin
			cnt_next = cnt_next + CW'(1);
		end
	end

	// hist[k] is the byte k positions back, hist[0] the current byte
	always_comb begin
		hist[0] = item_s1.data_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			hist[k] = recent_q[k-1];
		end
	end

	always_comb begin
		logic [LW-1:0] idx;
		logic [7:0]    pb;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			idx = '0;
			pb  = '0;
			eq[k] = 1'b1;
			if (k < int'(len)) begin
				idx = len - LW'(k) - LW'(1);
				// pattern bytes past the register pair read as zero
				pb  = idx[LW-1] ? 8'h00 : pat_all[8*idx[LW-2:0] +: 8];
				eq[k] = (pb == hist[k]);
			end
		end
		match = (int'(cnt_next) >= int'(len)) && (&eq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_cnt_q    <= '0;
			seen_file_q   <= 1'b0;
			seen_search_q <= 1'b0;
			for (int k = 0; k < DEPTH; k++) begin
				recent_q[k] <= '0;
			end
		end else if (adv_s1) begin
			seen_cnt_q    <= cnt_next;
			seen_file_q   <= (seen_file_q && !file_clr) || match;
			seen_search_q <= (seen_search_q && !search_clr) || match;
			for (int k = DEPTH - 1; k > 0; k--) begin
				recent_q[k] <= recent_q[k-1];
			end
			recent_q[0] <= item_s1.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv_s1) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result.file_found <= (seen_file_q && !file_clr) || match;
			result.file_done  <= item_s1.file_end;
			result.any_found  <= (seen_search_q && !search_clr) || match;
		end
	end

	// full input stage behind a stalled result must hold off the source
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid && !result_ready) |-> !item_ready)
		else $error("item_ready high while pipeline is blocked");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (result_valid && (result.file_done == $past(item_s1.file_end))))
		else $error("result does not follow the advancing byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(seen_cnt_q) <= MAX_PATTERN)
		else $error("fill count beyond window depth");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;

	localparam int PAT_MAX = bspf_pkg::MAX_PATTERN_DEF;
	localparam int LIMIT_CYCLES = 200_000;
	localparam logic [bspf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           item_valid = 1'b0;
	logic                           item_ready;
	bspf_pkg::item_t                item = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	bspf_pkg::result_t              result;
	logic                           wr_en = 1'b0;
	logic [bspf_pkg::CFG_IDX_W-1:0] wr_index = '0;
	logic [bspf_pkg::CFG_W-1:0]     wr_data = '0;

	// scanner state as the block should hold it
	logic [63:0] pat_low = '0;
	logic [63:0] pat_high = '0;
	logic [4:0]  pat_len = 5'd1;
	logic [7:0]  recent_window [PAT_MAX-1];
	int          fill_count = 0;
	bit          file_hit = 1'b0;
	bit          search_hit = 1'b0;

	bspf_pkg::result_t expected_flags [$];
	bspf_pkg::result_t want;
	int      errors = 0;
	int      results_seen = 0;
	int      bytes_sent = 0;
	bit      idle_on = 1'b1;
	int      hold_req = 0;
	int      hold_left = 0;

	byte_stream_pattern_finder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		foreach (recent_window[k]) recent_window[k] = 8'h00;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	function automatic int active_length();
		if (pat_len == 5'd0)
			return 1;
		if (pat_len > PAT_MAX)
			return PAT_MAX;
		return int'(pat_len);
	endfunction

	function automatic logic [7:0] pattern_byte(input int idx);
		logic [127:0] whole;
		whole = {pat_high, pat_low};
		return whole[8*idx +: 8];
	endfunction

	// clears come before the byte is counted, so a match on a start byte still shows
	function automatic bspf_pkg::result_t scan_byte(input bspf_pkg::item_t it);
		bspf_pkg::result_t r;
		int n;
		bit hit;
		n = active_length();
		if (it.file_start) begin
			fill_count = 0;
			file_hit = 1'b0;
		end
		if (it.new_search)
			search_hit = 1'b0;
		if (fill_count < PAT_MAX)
			fill_count++;
		hit = (fill_count >= n) && (pattern_byte(n - 1) == it.data_byte);
		for (int k = 1; k < n; k++) begin
			if (pattern_byte(n - 1 - k) != recent_window[k-1])
				hit = 1'b0;
		end
		if (hit) begin
			file_hit = 1'b1;
			search_hit = 1'b1;
		end
		for (int k = PAT_MAX - 2; k > 0; k--)
			recent_window[k] = recent_window[k-1];
		recent_window[0] = it.data_byte;
		r.file_found = file_hit;
		r.file_done = it.file_end;
		r.any_found = search_hit;
		return r;
	endfunction

	function automatic bspf_pkg::item_t make_item(input logic [7:0] b, input bit is_first,
			input bit is_last, input bit fresh);
		bspf_pkg::item_t it;
		it.data_byte = b;
		it.file_start = is_first;
		it.file_end = is_last;
		it.new_search = fresh;
		return it;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	// returns in the cycle of the transfer; valid stays up for a following send
	task automatic send_byte(input bspf_pkg::item_t it);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 6) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		expected_flags.push_back(scan_byte(it));
		bytes_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_flags.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_pattern(input logic [63:0] low, input logic [63:0] high,
			input logic [63:0] len_word);
		wait_drain();
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= bspf_pkg::REG_PATTERN_LOW;
		wr_data <= low;
		@(negedge clk);
		wr_index <= bspf_pkg::REG_PATTERN_HIGH;
		wr_data <= high;
		@(negedge clk);
		wr_index <= bspf_pkg::REG_PATTERN_LEN;
		wr_data <= len_word;
		@(negedge clk);
		// unmapped index, must change nothing
		wr_index <= REG_SPARE;
		wr_data <= {$urandom, $urandom};
		@(negedge clk);
		wr_en <= 1'b0;
		pat_low = low;
		pat_high = high;
		pat_len = len_word[4:0];
	endtask

	task automatic send_file(input int n_bytes, input bit fresh, input bit broken);
		bspf_pkg::item_t it;
		int n;
		int plant_at;
		logic [7:0] b;
		n = active_length();
		plant_at = -1;
		if (n_bytes >= n && $urandom_range(99) < 40)
			plant_at = $urandom_range(n_bytes - n);
		for (int k = 0; k < n_bytes; k++) begin
			if (plant_at >= 0 && k >= plant_at && k < plant_at + n)
				b = pattern_byte(k - plant_at);
			else if ($urandom_range(99) < 70)
				b = pattern_byte($urandom_range(n - 1));
			else
				b = 8'($urandom_range(255));
			if (broken)
				it = make_item(b, $urandom_range(99) < 10, $urandom_range(99) < 10,
					$urandom_range(99) < 5);
			else
				it = make_item(b, k == 0, k == n_bytes - 1, fresh && k == 0);
			send_byte(it);
		end
	endtask

	task automatic run_phase(input logic [4:0] len_code, input int count);
		logic [127:0] pat;
		logic [63:0] len_word;
		int start_count;
		int n;
		bit two_letter;
		two_letter = $urandom_range(2) == 0;
		for (int k = 0; k < 16; k++)
			pat[8*k +: 8] = two_letter ? ($urandom_range(1) ? 8'h41 : 8'h42)
				: 8'($urandom_range(255));
		len_word = {$urandom, $urandom};
		if ($urandom_range(1))
			len_word[63:5] = '0;
		len_word[4:0] = len_code;
		set_pattern(pat[63:0], pat[127:64], len_word);
		n = active_length();
		start_count = bytes_sent;
		while (bytes_sent - start_count < count) begin
			if ($urandom_range(99) < 3)
				wait_drain();
			send_file(($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, n + 6),
				$urandom_range(99) < 20, $urandom_range(99) < 12);
		end
	endtask

	task automatic test_defaults_after_reset();
		// reset pattern is a single zero byte; first byte arrives with no file start
		send_byte(make_item(8'h00, 1'b0, 1'b0, 1'b0));
		send_byte(make_item(8'hFF, 1'b1, 1'b1, 1'b1));
		send_byte(make_item(8'h00, 1'b1, 1'b1, 1'b0));
	endtask

	task automatic test_file_boundaries();
		set_pattern({40'h12_3456_789A, 24'hFF00FF}, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
		send_byte(make_item(8'hFF, 1'b1, 1'b0, 1'b1));
		send_byte(make_item(8'h00, 1'b0, 1'b1, 1'b0));
		// window holds the previous file, no match may span files
		send_byte(make_item(8'hFF, 1'b1, 1'b1, 1'b0));
		// continuing after the end without a new start
		send_byte(make_item(8'h00, 1'b0, 1'b0, 1'b0));
		send_byte(make_item(8'hFF, 1'b0, 1'b0, 1'b0));
		send_byte(make_item(8'h00, 1'b1, 1'b1, 1'b1));
	endtask

	task automatic test_full_length_pattern();
		// length field of 31 saturates to the full sixteen bytes
		set_pattern(64'h00FF_7E81_0123_4567, 64'hFF00_8001_FEDC_BA98, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int k = 0; k < PAT_MAX; k++)
			send_byte(make_item(pattern_byte(k), k == 0, k == PAT_MAX - 1, k == 0));
	endtask

	task automatic test_input_stall();
		set_pattern({$urandom, $urandom}, {$urandom, $urandom}, 64'd4);
		idle_on = 1'b0;
		send_file(3, 1'b1, 1'b0);
		// receiver holds off while the sender keeps offering
		hold_req = 80;
		while (bytes_sent < 60 + 30)
			send_file($urandom_range(1, 10), $urandom_range(1), 1'b0);
		idle_on = 1'b1;
		wait_drain();
	endtask

	task automatic test_random_configs();
		logic [4:0] lens [9];
		lens = '{5'd1, 5'd2, 5'd16, 5'd0, 5'd31, 5'd17, 5'd5, 5'd0, 5'd0};
		lens[7] = 5'($urandom_range(1, 16));
		lens[8] = 5'($urandom_range(0, 31));
		foreach (lens[i])
			run_phase(lens[i], 200);
	endtask

	task automatic test_no_idle_stretch();
		idle_on = 1'b0;
		run_phase(5'd3, 300);
		idle_on = 1'b1;
	endtask

	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= !(idle_on && $urandom_range(99) < 6);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (expected_flags.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing expected", results_seen));
			end else begin
				want = expected_flags.pop_front();
				if (result.file_found !== want.file_found)
					report_mismatch($sformatf("file_found got %b want %b at result %0d",
						result.file_found, want.file_found, results_seen));
				if (result.file_done !== want.file_done)
					report_mismatch($sformatf("file_done got %b want %b at result %0d",
						result.file_done, want.file_done, results_seen));
				if (result.any_found !== want.any_found)
					report_mismatch($sformatf("any_found got %b want %b at result %0d",
						result.any_found, want.any_found, results_seen));
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_defaults_after_reset();
		test_file_boundaries();
		test_full_length_pattern();
		test_input_stall();
		test_random_configs();
		test_no_idle_stretch();
		wait_drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
